// ===== sv/rpn_stack_evaluator_macros.svh =====
// Assertion macros shared by the evaluator RTL.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define RSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rpn_stack_evaluator: assertion failed");

// Next-cycle implication, checked outside reset.
`define RSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpn_stack_evaluator: assertion failed");

`else

`define RSE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RSE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/rse_pkg.sv =====
`timescale 1ns / 1ps

package rse_pkg;

   typedef logic [3:0]         kind_type;
   typedef logic [1:0]         status_type;
   typedef logic signed [31:0] q16_type;
   typedef logic [7:0]         depth_type;

   localparam kind_type KIND_PUSH  = 4'd0;
   localparam kind_type KIND_ADD   = 4'd1;
   localparam kind_type KIND_SUB   = 4'd2;
   localparam kind_type KIND_MUL   = 4'd3;
   localparam kind_type KIND_DIV   = 4'd4;
   localparam kind_type KIND_MOD   = 4'd5;
   localparam kind_type KIND_POP   = 4'd6;
   localparam kind_type KIND_PEEK  = 4'd7;
   localparam kind_type KIND_DUP   = 4'd8;
   localparam kind_type KIND_CLEAR = 4'd9;
   localparam kind_type KIND_SWAP  = 4'd10;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_OVER  = 2'd1;
   localparam status_type ST_UNDER = 2'd2;
   localparam status_type ST_ZDIV  = 2'd3;

   localparam q16_type Q16_MAX  = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN  = 32'sh8000_0000;
   localparam q16_type Q16_ZERO = 32'sh0000_0000;

   // The divider walks a 48-bit dividend one bit per cycle.
   localparam int DIV_BITS = 48;

endpackage

// ===== sv/rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps
// A result strobes after its item is accepted and passes RD1, RD2 and EXEC; swap and dup
// on an empty stack (two entries written) add WR2, mul adds MUL and FIN, and div and mod
// with a nonzero divisor add the 48-bit serial divider and FIN; a zero divisor does not.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset (synchronous, active high) empties the stack and drops any item in flight.
// The receiver cannot stall: each result is on rsp_* for exactly one cycle.
`include "rpn_stack_evaluator_macros.svh"

module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rse_pkg::kind_type   req_kind,
   input  rse_pkg::q16_type    req_operand,
   output logic                rsp_valid,
   output rse_pkg::q16_type    rsp_value,
   output rse_pkg::status_type rsp_status,
   output rse_pkg::depth_type  rsp_depth
);
   import rse_pkg::*;

   // The stack pointer must hold the full depth; the memory index only the entries.
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(DIV_BITS);

   // Sequencer states. Each item reads the top two entries through the single
   // read port in RD1 and RD2, then executes and commits.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD1  = 3'd1;
   localparam logic [2:0] S_RD2  = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_WR2  = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Operand stack: one write port and one registered read port.
   q16_type        mem [STACK_DEPTH];
   logic [AW-1:0]  rd_addr;
   q16_type        rd_data_ff;
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   q16_type        mem_wd;

   kind_type       kind_ff;
   q16_type        opnd_ff;
   q16_type        t1_ff;
   q16_type        rsp_value_ff;
   status_type     rsp_status_ff;

   // Second write of dup and swap.
   logic [AW-1:0]  w2_addr_ff;
   q16_type        w2_data_ff;

   // Arithmetic unit operands and the slot its result goes to.
   q16_type              a_ff, b_ff;
   logic signed [63:0]   prod_ff;
   logic [SPW-1:0]       push_sp_ff;
   status_type           stat_ff;
   logic                 is_mul_ff;
   logic                 is_mod_ff;
   logic [DIV_BITS-1:0]  dvd_ff;
   logic [31:0]          dvs_ff;
   logic [31:0]          rem_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 neg_q_ff, neg_a_ff;

   // Top two entries as the commands see them: a missing entry reads as zero.
   logic           has1, has2, full;
   q16_type        t1, t2;
   logic [SPW-1:0] sp_m1, sp_m2;

   assign has1  = (sp_ff != '0);
   assign has2  = (sp_ff >= SPW'(2));
   assign full  = (sp_ff == SPW'(STACK_DEPTH));
   assign t1    = has1 ? t1_ff : Q16_ZERO;
   assign t2    = has2 ? rd_data_ff : Q16_ZERO;
   assign sp_m1 = has1 ? sp_ff - SPW'(1) : '0;
   assign sp_m2 = has2 ? sp_ff - SPW'(2) : '0;

   // Execute-stage plan: stack writes, new depth, reported value and status.
   logic           p_w1, p_w2, p_mul, p_div;
   logic [AW-1:0]  p_w1a, p_w2a;
   q16_type        p_w1d, p_w2d, p_val;
   logic [SPW-1:0] p_sp;
   status_type     p_stat;
   logic [32:0]    sum33;
   q16_type        sum_sat;

   always_comb begin
      p_w1   = 1'b0;
      p_w2   = 1'b0;
      p_mul  = 1'b0;
      p_div  = 1'b0;
      p_w1a  = '0;
      p_w2a  = '0;
      p_w1d  = Q16_ZERO;
      p_w2d  = Q16_ZERO;
      p_val  = t1;
      p_sp   = sp_ff;
      p_stat = ST_OK;
      if (kind_ff == KIND_SUB) begin
         sum33 = {t2[31], t2} - {t1[31], t1};
      end else begin
         sum33 = {t2[31], t2} + {t1[31], t1};
      end
      if (sum33[32] != sum33[31]) begin
         sum_sat = sum33[32] ? Q16_MIN : Q16_MAX;
      end else begin
         sum_sat = sum33[31:0];
      end
      case (kind_ff)
         KIND_PUSH: begin
            if (full) begin
               p_stat = ST_OVER;
            end else begin
               p_w1  = 1'b1;
               p_w1a = sp_ff[AW-1:0];
               p_w1d = opnd_ff;
               p_sp  = sp_ff + SPW'(1);
               p_val = opnd_ff;
            end
         end
         KIND_ADD, KIND_SUB: begin
            p_stat = has2 ? ST_OK : ST_UNDER;
            p_w1   = 1'b1;
            p_w1a  = sp_m2[AW-1:0];
            p_w1d  = sum_sat;
            p_sp   = sp_m2 + SPW'(1);
            p_val  = sum_sat;
         end
         KIND_MUL: begin
            p_stat = has2 ? ST_OK : ST_UNDER;
            p_mul  = 1'b1;
         end
         KIND_DIV, KIND_MOD: begin
            if (t1 == Q16_ZERO) begin
               // Zero divisor: only the divisor is popped.
               p_stat = has1 ? ST_ZDIV : ST_UNDER;
               p_sp   = sp_m1;
               p_val  = t2;
            end else begin
               p_stat = has2 ? ST_OK : ST_UNDER;
               p_div  = 1'b1;
            end
         end
         KIND_POP: begin
            p_stat = has1 ? ST_OK : ST_UNDER;
            p_sp   = sp_m1;
         end
         KIND_PEEK: begin
            if (!has1) begin
               p_stat = ST_UNDER;
               p_w1   = 1'b1;
               p_w1a  = '0;
               p_sp   = SPW'(1);
            end
         end
         KIND_DUP: begin
            if (!has1) begin
               p_stat = ST_UNDER;
               p_w1   = 1'b1;
               p_w1a  = '0;
               p_w2   = 1'b1;
               p_w2a  = AW'(1);
               p_sp   = SPW'(2);
            end else if (full) begin
               p_stat = ST_OVER;
            end else begin
               p_w1  = 1'b1;
               p_w1a = sp_ff[AW-1:0];
               p_w1d = t1;
               p_sp  = sp_ff + SPW'(1);
            end
         end
         KIND_CLEAR: begin
            p_sp  = '0;
            p_val = Q16_ZERO;
         end
         KIND_SWAP: begin
            p_stat = has2 ? ST_OK : ST_UNDER;
            p_w1   = 1'b1;
            p_w1a  = sp_m2[AW-1:0];
            p_w1d  = t1;
            p_w2   = 1'b1;
            p_w2a  = AW'(sp_m2 + SPW'(1));
            p_w2d  = t2;
            p_sp   = sp_m2 + SPW'(2);
            p_val  = t2;
         end
         default: begin
         end
      endcase
   end

   // Multiply: drop 16 fraction bits toward zero, then saturate.
   logic signed [63:0] prod_adj, prod_sc;
   q16_type            mul_res;

   always_comb begin
      prod_adj = prod_ff + (prod_ff[63] ? 64'sd65535 : 64'sd0);
      prod_sc  = prod_adj >>> 16;
      if (prod_sc > 64'sh0000_0000_7FFF_FFFF) begin
         mul_res = Q16_MAX;
      end else if (prod_sc < -64'sh0000_0000_8000_0000) begin
         mul_res = Q16_MIN;
      end else begin
         mul_res = prod_sc[31:0];
      end
   end

   // Divider: restoring, one quotient bit per cycle on magnitudes.
   logic [32:0]  rsh;
   logic         ge;
   logic [31:0]  rem_in;
   logic [31:0]  abs_a, abs_b;
   q16_type      div_res;

   assign rsh    = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign ge     = (rsh >= {1'b0, dvs_ff});
   assign rem_in = ge ? 32'(rsh - {1'b0, dvs_ff}) : rsh[31:0];
   assign abs_a  = t2[31] ? 32'(-t2) : t2;
   assign abs_b  = t1[31] ? 32'(-t1) : t1;

   always_comb begin
      if (is_mod_ff) begin
         div_res = neg_a_ff ? 32'(-rem_ff) : rem_ff;
      end else if (neg_q_ff) begin
         div_res = (dvd_ff > DIV_BITS'(32'h8000_0000)) ? Q16_MIN : 32'(-dvd_ff[31:0]);
      end else begin
         div_res = (dvd_ff > DIV_BITS'(32'h7FFF_FFFF)) ? Q16_MAX : dvd_ff[31:0];
      end
   end

   // Read address: top entry first, then the one below it.
   always_comb begin
      if (state_ff == S_RD2) begin
         rd_addr = AW'(sp_ff - SPW'(2));
      end else begin
         rd_addr = AW'(sp_ff - SPW'(1));
      end
   end

   // Write port and sequencing.
   q16_type arith_res;
   assign arith_res = is_mul_ff ? mul_res : div_res;

   always_comb begin
      mem_we       = 1'b0;
      mem_wa       = '0;
      mem_wd       = Q16_ZERO;
      state_in     = state_ff;
      sp_in        = sp_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            state_in = S_RD2;
         end
         S_RD2: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (p_mul) begin
               state_in = S_MUL;
            end else if (p_div) begin
               state_in = S_DIV;
            end else begin
               mem_we = p_w1;
               mem_wa = p_w1a;
               mem_wd = p_w1d;
               sp_in  = p_sp;
               if (p_w2) begin
                  state_in = S_WR2;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_WR2: begin
            mem_we       = 1'b1;
            mem_wa       = w2_addr_ff;
            mem_wd       = w2_data_ff;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_MUL: begin
            state_in = S_FIN;
         end
         S_DIV: begin
            if (cnt_ff == CW'(DIV_BITS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            mem_we       = 1'b1;
            mem_wa       = push_sp_ff[AW-1:0];
            mem_wd       = arith_res;
            sp_in        = push_sp_ff + SPW'(1);
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         kind_ff <= req_kind;
         opnd_ff <= req_operand;
      end
      if (state_ff == S_RD2) begin
         t1_ff <= rd_data_ff;
      end
      if (state_ff == S_EXEC) begin
         rsp_value_ff  <= p_val;
         rsp_status_ff <= p_stat;
         w2_addr_ff    <= p_w2a;
         w2_data_ff    <= p_w2d;
         a_ff          <= t2;
         b_ff          <= t1;
         push_sp_ff    <= sp_m2;
         stat_ff       <= p_stat;
         is_mul_ff     <= p_mul;
         is_mod_ff     <= (kind_ff == KIND_MOD);
         dvd_ff        <= (kind_ff == KIND_MOD) ? DIV_BITS'(abs_a) : {abs_a, 16'h0000};
         dvs_ff        <= abs_b;
         rem_ff        <= '0;
         cnt_ff        <= '0;
         neg_q_ff      <= t2[31] ^ t1[31];
         neg_a_ff      <= t2[31];
      end
      if (state_ff == S_MUL) begin
         prod_ff <= a_ff * b_ff;
      end
      if (state_ff == S_DIV) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[DIV_BITS-2:0], ge};
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (state_ff == S_FIN) begin
         rsp_value_ff  <= arith_res;
         rsp_status_ff <= stat_ff;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_depth  = 8'(sp_ff);

   // The stack pointer never passes the stack's depth.
   `RSE_ASSERT_IMPL(a_sp_range, clock, reset, 1'b1, sp_ff <= SPW'(STACK_DEPTH))
   // An accepted item makes the block busy on the next cycle.
   `RSE_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // Each item gives one result strobe, never two in a row.
   `RSE_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid)
   // The divider only runs while its step count is in range.
   `RSE_ASSERT_IMPL(a_div_cnt, clock, reset, state_ff == S_DIV, cnt_ff <= CW'(DIV_BITS - 1))

endmodule

// ===== test/tb_rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator;
   import rse_pkg::*;

   localparam int DEPTH_MAX = 128;
   localparam int IDLE_LIMIT = 4000;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   kind_type   req_kind;
   q16_type    req_operand;
   logic       rsp_valid;
   q16_type    rsp_value;
   status_type rsp_status;
   depth_type  rsp_depth;

   rpn_stack_evaluator #(.STACK_DEPTH(DEPTH_MAX)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_operand(req_operand),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value),
      .rsp_status(rsp_status), .rsp_depth(rsp_depth)
   );

   typedef struct packed {
      q16_type    value;
      status_type status;
      depth_type  depth;
   } answer_type;

   // Shadow copy of the operand stack and its pointer.
   q16_type   shadow_stack [DEPTH_MAX];
   int        shadow_sp;
   status_type cmd_flag;

   answer_type pending_answers [$];
   int        mismatches;
   int        items_sent;
   int        answers_seen;
   int        idle_cycles;
   int        send_gap_pct;
   bit        timed_out;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void raise_flag(status_type s);
      if (cmd_flag == ST_OK) cmd_flag = s;
   endfunction

   function automatic q16_type clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return Q16_MAX;
      if (v < -64'sd2147483648) return Q16_MIN;
      return v[31:0];
   endfunction

   function automatic void shadow_push(q16_type v);
      if (shadow_sp < DEPTH_MAX) begin
         shadow_stack[shadow_sp] = v;
         shadow_sp++;
      end else begin
         raise_flag(ST_OVER);
      end
   endfunction

   function automatic q16_type shadow_pop(output bit was_empty);
      was_empty = 1'b0;
      if (shadow_sp > 0) begin
         shadow_sp--;
         return shadow_stack[shadow_sp];
      end
      raise_flag(ST_UNDER);
      was_empty = 1'b1;
      return Q16_ZERO;
   endfunction

   // Applies one command to the shadow stack and returns the answer it produces.
   function automatic answer_type evaluate_command(kind_type kind, q16_type opnd);
      q16_type a, b, v;
      bit e, de;
      logic signed [63:0] wide;
      bit reported;
      answer_type ans;
      cmd_flag = ST_OK;
      reported = 1'b0;
      v = Q16_ZERO;
      case (kind)
         KIND_PUSH: shadow_push(opnd);
         KIND_ADD, KIND_SUB, KIND_MUL: begin
            b = shadow_pop(e);
            a = shadow_pop(e);
            if (kind == KIND_ADD) wide = 64'(a) + 64'(b);
            else if (kind == KIND_SUB) wide = 64'(a) - 64'(b);
            else wide = (64'(a) * 64'(b)) / 64'sd65536;
            shadow_push(clamp32(wide));
         end
         KIND_DIV, KIND_MOD: begin
            b = shadow_pop(de);
            if (b == 0) begin
               if (!de) raise_flag(ST_ZDIV);
            end else begin
               a = shadow_pop(e);
               if (kind == KIND_DIV) wide = (64'(a) * 64'sd65536) / 64'(b);
               else wide = 64'(a) % 64'(b);
               shadow_push(clamp32(wide));
            end
         end
         KIND_POP: begin
            v = shadow_pop(e);
            reported = 1'b1;
         end
         KIND_PEEK: begin
            v = shadow_pop(e);
            shadow_push(v);
            reported = 1'b1;
         end
         KIND_DUP: begin
            a = shadow_pop(e);
            shadow_push(a);
            shadow_push(a);
         end
         KIND_CLEAR: shadow_sp = 0;
         KIND_SWAP: begin
            a = shadow_pop(e);
            b = shadow_pop(e);
            shadow_push(a);
            shadow_push(b);
         end
         default: ;
      endcase
      if (!reported) v = (shadow_sp > 0) ? shadow_stack[shadow_sp - 1] : Q16_ZERO;
      ans.value = v;
      ans.status = cmd_flag;
      ans.depth = depth_type'(shadow_sp);
      return ans;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      mismatches++;
   endtask

   // Sends one item, with a random gap before it per the current idle share.
   // Start stays high between back-to-back items; busy keeps the block from
   // taking the next item until the current one is done.
   task automatic send_command(kind_type kind, q16_type opnd);
      if ($urandom_range(99, 0) < send_gap_pct) begin
         start <= 1'b0;
         req_operand <= $urandom;
         @(posedge clock);
         while ($urandom_range(99, 0) < send_gap_pct) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_operand <= opnd;
      @(posedge clock);
      while (busy) @(posedge clock);
      // The item is taken at this edge; predict now so the answer is queued in time.
      pending_answers.push_back(evaluate_command(kind, opnd));
      items_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_answers.size() != 0 && !timed_out) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Checks each result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         answer_type want;
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $display("result with no command waiting");
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_depth !== want.depth)
               report_mismatch("depth", 32'(rsp_depth), 32'(want.depth));
         end
      end
   end

   // Watchdog: counts cycles in which neither a command nor a result is taken.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired");
         $display("status: fail");
         $finish;
      end
   end

   function automatic q16_type random_value();
      case ($urandom_range(5, 0))
         0: return Q16_MAX;
         1: return Q16_MIN;
         2: return Q16_ZERO;
         3: return q16_type'($urandom_range(8, 0)) <<< 16;
         4: return q16_type'($signed($urandom_range(2047, 0)) - 1024) <<< $urandom_range(18, 8);
         default: return $urandom;
      endcase
   endfunction

   // Directed: extremes, each operation, and special cases on an empty
   // and a one-entry stack.
   task automatic test_directed();
      send_command(KIND_POP, 0);
      send_command(KIND_PEEK, 0);
      send_command(KIND_DUP, 0);
      send_command(KIND_CLEAR, 0);
      send_command(KIND_PUSH, Q16_MAX);
      send_command(KIND_SWAP, 0);
      send_command(KIND_PUSH, Q16_MAX);
      send_command(KIND_ADD, 0);
      send_command(KIND_PUSH, Q16_MIN);
      send_command(KIND_SUB, 0);
      send_command(KIND_PUSH, Q16_MIN);
      send_command(KIND_MUL, 0);
      send_command(KIND_PUSH, Q16_ZERO);
      send_command(KIND_DIV, 0);
      send_command(KIND_PUSH, Q16_ZERO);
      send_command(KIND_MOD, 0);
      send_command(KIND_CLEAR, 0);
      send_command(KIND_DIV, 0);
      send_command(KIND_PUSH, -32'sd65536);
      send_command(KIND_PUSH, 32'sh0000_0001);
      send_command(KIND_DIV, 0);
      send_command(KIND_PUSH, -32'sd196608);
      send_command(KIND_MOD, 0);
      send_command(kind_type'(4'd11), 0);
      send_command(kind_type'(4'd15), 0);
   endtask

   // Fills the stack past its limit, then overflows with dup.
   task automatic test_full_stack();
      send_command(KIND_CLEAR, 0);
      repeat (DEPTH_MAX + 2) send_command(KIND_PUSH, $urandom);
      send_command(KIND_DUP, 0);
      send_command(KIND_POP, 0);
      send_command(KIND_DUP, 0);
      send_command(KIND_SWAP, 0);
      send_command(KIND_PEEK, 0);
   endtask

   // Mostly well-formed expressions with random values, plus noise commands.
   task automatic test_random(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99, 0);
         if (shadow_sp < 2 && k < 60) send_command(KIND_PUSH, random_value());
         else if (k < 30) send_command(KIND_PUSH, random_value());
         else if (k < 80) send_command(kind_type'($urandom_range(5, 1)), $urandom);
         else if (k < 97) send_command(kind_type'($urandom_range(10, 6)), $urandom);
         else send_command(kind_type'($urandom_range(15, 0)), $urandom);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_PUSH;
      req_operand = '0;
      mismatches = 0;
      items_sent = 0;
      answers_seen = 0;
      idle_cycles = 0;
      timed_out = 1'b0;
      shadow_sp = 0;
      send_gap_pct = 34;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_stack();
      test_random(300);
      // Hold off until every answer is back, then continue with other gaps.
      wait_drained();
      send_gap_pct = 75;
      test_random(300);
      send_gap_pct = 0;
      test_random(300);
      wait_drained();

      $display("sent %0d commands, checked %0d results", items_sent, answers_seen);
      $display("covered all kinds, saturation, empty and full stack, zero divisors");
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== rpn_stack_evaluator.f =====
+incdir+sv
sv/rse_pkg.sv
sv/rpn_stack_evaluator.sv
test/tb_rpn_stack_evaluator.sv
